FILE: rtl/pepm_pkg.sv
package pepm_pkg;

  localparam int MaxTermsDef = 6;
  localparam int StoreSlots  = 1024;
  localparam int SlotW       = $clog2(StoreSlots);
  localparam int MarkW       = 32;
  localparam int CountW      = 20;
  localparam int PosW        = 20;
  localparam int TermW       = 3;
  localparam int OffsetW     = 11;
  localparam int QueueDepth  = 4;
  localparam int ApbDataW    = 32;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  localparam int RegNumTerms = 0;
  localparam int RegStop     = 1;
  localparam int RegOffset0  = 2;

  typedef enum logic [1:0] {
    CMD_POS = 2'd0,
    CMD_EOW = 2'd1,
    CMD_EOD = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    K_FIRST = 3'd0,
    K_MID   = 3'd1,
    K_LAST  = 3'd2,
    K_EOW   = 3'd3,
    K_EOD   = 3'd4
  } op_kind_e;

  typedef enum logic [2:0] {
    ST_CLEAR    = 3'd0,
    ST_IDLE     = 3'd1,
    ST_CMP      = 3'd2,
    ST_WRAP_CHK = 3'd3
  } back_state_e;

  typedef struct packed {
    op_kind_e           kind;
    logic               neg;
    logic [SlotW-1:0]   slot;
    logic [TermW-1:0]   term;
  } q_entry_t;

  typedef struct packed {
    logic [TermW-1:0] n_eff;
    logic             stop;
  } cfg_ctl_t;

endpackage

FILE: rtl/exact_phrase_position_matcher.sv
// Exact phrase position matcher. Term positions, end-of-window and end-of-document
// transactions enter on the slave stream; a front stage classifies each one, adds
// the term offset to form a slot of the 1024-entry mark store, drops positions of
// terms outside the phrase and unused commands, and queues the rest four deep. The
// back stage executes queued work in order: a term-0 position writes its mark, a
// middle or last term position reads the store, then compares and writes back, and
// an end-of-window advances the generation, then checks for a wrap. The input
// side takes one transaction a cycle until the queue fills. After reset the store
// is cleared, during which s_axis_tready stays low; a generation wrap at end of
// window clears it again while the queue keeps filling. Each
// end-of-document yields one master transaction with the saturating match count.
// Registers sit at byte addresses 4*i: num_terms, stop_after_first, offset_0..5.
module exact_phrase_position_matcher import pepm_pkg::*; #(
  parameter int MaxTerms = MaxTermsDef,
  parameter int AddrW    = $clog2((RegOffset0 + MaxTerms) * 4)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // term [2:0], position [22:3], zero [23]
  input  logic [23:0]         s_axis_tdata,
  // cmd [1:0]
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // phrase_freq [19:0], zero [23:20]
  output logic [23:0]         m_axis_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  cfg_ctl_t                         ctl;
  logic [MaxTerms-1:0][OffsetW-1:0] offsets;
  logic                             init_done;
  logic                             q_full, q_empty, q_push, q_pop;
  q_entry_t                         q_in, q_out;
  logic [CountW-1:0]                freq;

  pepm_cfg #(
    .MaxTerms (MaxTerms),
    .AddrW    (AddrW)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .ctl_o     (ctl),
    .offsets_o (offsets)
  );

  pepm_front #(
    .MaxTerms (MaxTerms)
  ) u_front (
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .cmd_i       (s_axis_tuser),
    .term_i      (s_axis_tdata[TermW-1:0]),
    .position_i  (s_axis_tdata[TermW+PosW-1:TermW]),
    .ctl_i       (ctl),
    .offsets_i   (offsets),
    .init_done_i (init_done),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (q_in)
  );

  pepm_fifo #(
    .Width ($bits(q_entry_t)),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_in),
    .pop_i   (q_pop),
    .rdata_o (q_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  pepm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .q_empty_i   (q_empty),
    .q_entry_i   (q_out),
    .q_pop_o     (q_pop),
    .init_done_o (init_done),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (freq)
  );

  assign m_axis_tdata = {4'b0000, freq};

  a_no_accept_during_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !init_done |-> !s_axis_tready)
    else $error("input accepted before store clear finished");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("queue pop while empty");

  a_result_from_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(q_pop))
    else $error("result raised without a queued end of document");

endmodule

FILE: rtl/pepm_ram.sv
module pepm_ram import pepm_pkg::*; #(
  parameter int Width = MarkW,
  parameter int Depth = StoreSlots
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/pepm_cfg.sv
module pepm_cfg import pepm_pkg::*; #(
  parameter int MaxTerms = MaxTermsDef,
  parameter int AddrW    = $clog2((RegOffset0 + MaxTerms) * 4)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [AddrW-1:0]                  paddr,
  input  logic [ApbDataW-1:0]               pwdata,
  output logic [ApbDataW-1:0]               prdata,
  output logic                              pready,
  output cfg_ctl_t                          ctl_o,
  output logic [MaxTerms-1:0][OffsetW-1:0]  offsets_o
);

  localparam int IdxW     = AddrW - 2;
  localparam int TermIdxW = (MaxTerms > 1) ? $clog2(MaxTerms) : 1;
  localparam logic [TermW-1:0] MaxN = TermW'(MaxTerms);
  localparam logic [TermW-1:0] MinN = TermW'(2);

  logic [TermW-1:0]                 num_terms_q;
  logic                             stop_q;
  logic [MaxTerms-1:0][OffsetW-1:0] offset_q;
  logic [IdxW-1:0]                  reg_idx;
  logic                             wr_en;
  logic                             is_off;
  logic [TermIdxW-1:0]              off_idx;

  assign reg_idx = paddr[AddrW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign is_off  = (int'(reg_idx) >= RegOffset0) && (int'(reg_idx) < RegOffset0 + MaxTerms);
  assign off_idx = TermIdxW'(int'(reg_idx) - RegOffset0);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_terms_q <= MinN;
      stop_q      <= 1'b0;
      offset_q    <= '0;
    end else if (wr_en) begin
      if (int'(reg_idx) == RegNumTerms) begin
        num_terms_q <= pwdata[TermW-1:0];
      end else if (int'(reg_idx) == RegStop) begin
        stop_q <= pwdata[0];
      end else if (is_off) begin
        offset_q[off_idx] <= pwdata[OffsetW-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (int'(reg_idx) == RegNumTerms) begin
      prdata = ApbDataW'(num_terms_q);
    end else if (int'(reg_idx) == RegStop) begin
      prdata = ApbDataW'(stop_q);
    end else if (is_off) begin
      prdata = ApbDataW'(offset_q[off_idx]);
    end
  end

  always_comb begin
    ctl_o.stop = stop_q;
    if (num_terms_q < MinN) begin
      ctl_o.n_eff = MinN;
    end else if (num_terms_q > MaxN) begin
      ctl_o.n_eff = MaxN;
    end else begin
      ctl_o.n_eff = num_terms_q;
    end
  end

  assign offsets_o = offset_q;

endmodule

FILE: rtl/pepm_front.sv
module pepm_front import pepm_pkg::*; #(
  parameter int MaxTerms = MaxTermsDef
) (
  input  logic                             s_valid_i,
  output logic                             s_ready_o,
  input  logic [1:0]                       cmd_i,
  input  logic [TermW-1:0]                 term_i,
  input  logic [PosW-1:0]                  position_i,
  input  cfg_ctl_t                         ctl_i,
  input  logic [MaxTerms-1:0][OffsetW-1:0] offsets_i,
  input  logic                             init_done_i,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output q_entry_t                         q_entry_o
);

  localparam int TermIdxW = (MaxTerms > 1) ? $clog2(MaxTerms) : 1;
  localparam int SumW     = PosW + 2;

  logic [OffsetW-1:0] off;
  logic [SumW-1:0]    sum;
  logic               keep;

  assign off = offsets_i[term_i[TermIdxW-1:0]];
  assign sum = {2'b00, position_i} + {{(SumW - OffsetW){off[OffsetW-1]}}, off};

  always_comb begin
    q_entry_o.neg  = sum[SumW-1];
    q_entry_o.slot = sum[SlotW-1:0];
    q_entry_o.term = term_i;
    q_entry_o.kind = K_EOD;
    keep           = 1'b0;
    case (cmd_i)
      CMD_POS: begin
        keep = term_i < ctl_i.n_eff;
        if (term_i == '0) begin
          q_entry_o.kind = K_FIRST;
        end else if (term_i == ctl_i.n_eff - TermW'(1)) begin
          q_entry_o.kind = K_LAST;
        end else begin
          q_entry_o.kind = K_MID;
        end
      end
      CMD_EOW: begin
        keep           = 1'b1;
        q_entry_o.kind = K_EOW;
      end
      CMD_EOD: begin
        keep           = 1'b1;
        q_entry_o.kind = K_EOD;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign s_ready_o = init_done_i && !q_full_i;
  assign q_push_o  = s_valid_i && s_ready_o && keep;

endmodule

FILE: rtl/pepm_fifo.sv
module pepm_fifo import pepm_pkg::*; #(
  parameter int Width = $bits(q_entry_t),
  parameter int Depth = QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(Depth);
  localparam logic [PtrW-1:0] LastP  = PtrW'(Depth - 1);

  logic [Width-1:0] buf_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = cnt_q == DepthC;
  assign empty_o = cnt_q == '0;
  assign rdata_o = buf_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastP) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == LastP) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= wdata_i;
    end
  end

endmodule

FILE: rtl/pepm_back.sv
module pepm_back import pepm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_ctl_t          ctl_i,
  input  logic              q_empty_i,
  input  q_entry_t          q_entry_i,
  output logic              q_pop_o,
  output logic              init_done_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CountW-1:0] out_data_o
);

  back_state_e       state_q, state_d;
  logic [MarkW-1:0]  gen_q, gen_d;
  logic [CountW-1:0] count_q, count_d;
  logic              stopped_q, stopped_d;
  logic              init_done_q, init_done_d;
  logic [SlotW-1:0]  clr_q, clr_d;
  logic              out_valid_q, out_valid_d;
  logic [CountW-1:0] out_data_q, out_data_d;
  logic [MarkW-1:0]  want_q, want_d;
  logic [SlotW-1:0]  op_slot_q, op_slot_d;
  logic              op_last_q, op_last_d;

  logic              ram_we, ram_re;
  logic [SlotW-1:0]  ram_addr;
  logic [MarkW-1:0]  ram_wdata, ram_rdata;
  logic              out_free;
  logic [MarkW:0]    wrap_sum;

  pepm_ram #(
    .Width (MarkW),
    .Depth (StoreSlots)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign wrap_sum = {1'b0, gen_q} + (MarkW + 1)'(ctl_i.n_eff) + (MarkW + 1)'(1);

  always_comb begin
    state_d     = state_q;
    gen_d       = gen_q;
    count_d     = count_q;
    stopped_d   = stopped_q;
    init_done_d = init_done_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    want_d      = want_q;
    op_slot_d   = op_slot_q;
    op_last_d   = op_last_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_addr    = q_entry_i.slot;
    ram_wdata   = gen_q;
    q_pop_o     = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + SlotW'(1);
        if (clr_q == {SlotW{1'b1}}) begin
          state_d     = ST_IDLE;
          init_done_d = 1'b1;
        end
      end
      ST_IDLE: begin
        if (!q_empty_i && (q_entry_i.kind != K_EOD || out_free)) begin
          q_pop_o = 1'b1;
          case (q_entry_i.kind)
            K_FIRST: begin
              ram_we = !stopped_q;
            end
            K_MID, K_LAST: begin
              if (!stopped_q && !q_entry_i.neg) begin
                ram_re    = 1'b1;
                want_d    = gen_q + MarkW'(q_entry_i.term) - MarkW'(1);
                op_slot_d = q_entry_i.slot;
                op_last_d = q_entry_i.kind == K_LAST;
                state_d   = ST_CMP;
              end
            end
            K_EOW: begin
              gen_d   = gen_q + MarkW'(ctl_i.n_eff) - MarkW'(1);
              state_d = ST_WRAP_CHK;
            end
            K_EOD: begin
              out_valid_d = 1'b1;
              out_data_d  = count_q;
              count_d     = '0;
              stopped_d   = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_CMP: begin
        state_d   = ST_IDLE;
        ram_addr  = op_slot_q;
        ram_wdata = want_q + MarkW'(1);
        if (ram_rdata == want_q) begin
          if (!op_last_q) begin
            ram_we = 1'b1;
          end else begin
            if (count_q != CountMax) begin
              count_d = count_q + CountW'(1);
            end
            if (ctl_i.stop) begin
              stopped_d = 1'b1;
            end
          end
        end
      end
      ST_WRAP_CHK: begin
        state_d = ST_IDLE;
        if (wrap_sum[MarkW]) begin
          gen_d   = MarkW'(1);
          clr_d   = '0;
          state_d = ST_CLEAR;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      gen_q       <= MarkW'(1);
      count_q     <= '0;
      stopped_q   <= 1'b0;
      init_done_q <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gen_q       <= gen_d;
      count_q     <= count_d;
      stopped_q   <= stopped_d;
      init_done_q <= init_done_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    want_q     <= want_d;
    op_slot_q  <= op_slot_d;
    op_last_q  <= op_last_d;
  end

  assign init_done_o = init_done_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: test/phrase_freq_checker.sv
`timescale 1ns / 1ps

module phrase_freq_checker
  import pepm_pkg::*;
#(
  parameter int AddrW = $clog2((RegOffset0 + MaxTermsDef) * 4)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  // term [2:0], position [22:3], zero [23]
  input  logic [23:0]         s_axis_tdata,
  // cmd [1:0]
  input  logic [1:0]          s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // phrase_freq [19:0], zero [23:20]
  input  logic [23:0]         m_axis_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [AddrW-1:0]    paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output int                  mismatch_cnt_o,
  output int                  freq_pending_o
);

  logic [MarkW-1:0]   mark_store [StoreSlots];
  logic [MarkW-1:0]   generation;
  logic [CountW-1:0]  match_count;
  logic               stopped;
  logic [TermW-1:0]   num_terms;
  logic               stop_first;
  logic [OffsetW-1:0] term_offset [MaxTermsDef];

  logic [CountW-1:0]  freq_q [$];
  logic [CountW-1:0]  want_freq;
  int                 reg_idx;
  int                 mismatch_cnt;

  task automatic track_transaction(input logic [1:0] cmd, input logic [TermW-1:0] term,
                                   input logic [PosW-1:0] pos);
    logic [TermW-1:0] n_eff;
    logic [MarkW-1:0] sum;
    logic [MarkW-1:0] want;
    logic [MarkW:0]   lookahead;
    logic [SlotW-1:0] slot;
    n_eff = (num_terms < 3'd2) ? 3'd2 :
            (num_terms > TermW'(MaxTermsDef)) ? TermW'(MaxTermsDef) : num_terms;
    case (cmd)
      CMD_POS: begin
        if (term < n_eff && !stopped) begin
          sum  = MarkW'(pos) +
                 {{(MarkW-OffsetW){term_offset[term][OffsetW-1]}}, term_offset[term]};
          slot = sum[SlotW-1:0];
          want = generation + MarkW'(term) - 1;
          if (term == '0) begin
            mark_store[slot] = generation;
          end else if (!sum[MarkW-1] && mark_store[slot] == want) begin
            if (term < n_eff - 3'd1) begin
              mark_store[slot] = want + 1;
            end else begin
              if (match_count != CountMax) match_count = match_count + 1;
              if (stop_first) stopped = 1'b1;
            end
          end
        end
      end
      CMD_EOW: begin
        generation = generation + MarkW'(n_eff) - 1;
        lookahead  = {1'b0, generation} + (MarkW+1)'(n_eff) + 1;
        // generation wrap clears the whole store
        if (lookahead[MarkW]) begin
          generation = 1;
          for (int i = 0; i < StoreSlots; i++) mark_store[i] = '0;
        end
      end
      CMD_EOD: begin
        freq_q.push_back(match_count);
        match_count = '0;
        stopped     = 1'b0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < StoreSlots; i++) mark_store[i] = '0;
      for (int i = 0; i < MaxTermsDef; i++) term_offset[i] = '0;
      generation     = 1;
      match_count    = '0;
      stopped        = 1'b0;
      num_terms      = 3'd2;
      stop_first     = 1'b0;
      mismatch_cnt   = 0;
      freq_q.delete();
      mismatch_cnt_o <= 0;
      freq_pending_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        reg_idx = int'(paddr) / 4;
        if (reg_idx == RegNumTerms) begin
          num_terms = pwdata[TermW-1:0];
        end else if (reg_idx == RegStop) begin
          stop_first = pwdata[0];
        end else if (reg_idx >= RegOffset0 && reg_idx < RegOffset0 + MaxTermsDef) begin
          term_offset[reg_idx - RegOffset0] = pwdata[OffsetW-1:0];
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (freq_q.size() == 0) begin
          $display("%0t: phrase_freq expected none, got %0d", $time,
                   m_axis_tdata[CountW-1:0]);
          mismatch_cnt++;
        end else begin
          want_freq = freq_q.pop_front();
          if (m_axis_tdata[CountW-1:0] !== want_freq) begin
            $display("%0t: phrase_freq expected %0d, got %0d", $time, want_freq,
                     m_axis_tdata[CountW-1:0]);
            mismatch_cnt++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        track_transaction(s_axis_tuser, s_axis_tdata[TermW-1:0], s_axis_tdata[TermW +: PosW]);
      end
      mismatch_cnt_o <= mismatch_cnt;
      freq_pending_o <= freq_q.size();
    end
  end

endmodule

FILE: test/exact_phrase_position_matcher_tb.sv
`timescale 1ns / 1ps

module exact_phrase_position_matcher_tb;
  import pepm_pkg::*;

  localparam int AddrW       = $clog2((RegOffset0 + MaxTermsDef) * 4);
  localparam int LimitCycles = 1000000;
  localparam int DrainCycles = 1100;
  localparam int LongHold    = 300;
  localparam int PhaseItems  = 240;
  localparam int NumPhases   = 8;
  localparam int PosMax      = (1 << PosW) - 1;

  localparam logic [1:0] CmdUnused = 2'd3;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata;
  logic [1:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [23:0]         m_axis_tdata;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrW-1:0]    paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  int   err_cnt;
  int   freq_pending;
  int   cycle_cnt;
  int   phase_items;
  int   tx_calm;
  int   n_eff;
  int   cfg_terms;
  int   cfg_stop;
  int   cfg_off [MaxTermsDef];
  logic random_part;

  exact_phrase_position_matcher i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  phrase_freq_checker #(
    .AddrW (AddrW)
  ) i_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatch_cnt_o (err_cnt),
    .freq_pending_o (freq_pending)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LimitCycles) begin
      $display("exact_phrase_position_matcher_tb: done, errors");
      $finish;
    end
  end

  function automatic int tx_gap();
    int r;
    if (tx_calm > 0) begin
      tx_calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) tx_calm = $urandom_range(20, 80);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [TermW-1:0] term,
                           input logic [PosW-1:0] pos);
    int gap;
    gap = tx_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {1'b0, pos, term};
    do @(posedge clk_i); while (!s_axis_tready);
    phase_items++;
  endtask

  task automatic write_reg(input int idx, input logic [ApbDataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(idx * 4);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_config();
    write_reg(RegNumTerms, ApbDataW'(cfg_terms));
    write_reg(RegStop, ApbDataW'(cfg_stop));
    for (int t = 0; t < MaxTermsDef; t++) begin
      write_reg(RegOffset0 + t, ApbDataW'(cfg_off[t][OffsetW-1:0]));
    end
    n_eff = (cfg_terms < 2) ? 2 : (cfg_terms > MaxTermsDef) ? MaxTermsDef : cfg_terms;
  endtask

  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (freq_pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send_noise();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      send_item(CmdUnused, TermW'($urandom), PosW'($urandom));
    end else if (r == 1) begin
      send_item(CMD_EOW, '0, '0);
    end else if (r == 2) begin
      send_item(CMD_POS, TermW'($urandom), PosW'($urandom_range(0, 2047)));
    end else begin
      send_item(CMD_POS, TermW'($urandom), PosW'($urandom));
    end
  endtask

  // anchors are slots-to-be; each term hits them through its own offset
  task automatic send_window();
    int base;
    int n_anch;
    int pos;
    int anch [$];
    base   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, PosMax);
    n_anch = $urandom_range(0, 5);
    for (int i = 0; i < n_anch; i++) anch.push_back(base + $urandom_range(0, 1023));
    for (int t = 0; t < n_eff; t++) begin
      foreach (anch[i]) begin
        pos = anch[i] - cfg_off[t];
        if ($urandom_range(0, 9) != 0 && pos >= 0 && pos <= PosMax) begin
          send_item(CMD_POS, TermW'(t), PosW'(pos));
        end
      end
      if ($urandom_range(0, 9) == 0) send_noise();
    end
    send_item(CMD_EOW, '0, '0);
  endtask

  task automatic send_doc();
    repeat ($urandom_range(1, 3)) begin
      send_window();
      if ($urandom_range(0, 7) == 0) send_noise();
    end
    send_item(CMD_EOD, '0, '0);
  endtask

  // receiver: random stalls, one long hold-off once the random part runs
  initial begin
    int   burst;
    int   stall;
    int   r;
    logic held;
    held = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      stall = (r < 70) ? $urandom_range(1, 3) :
              (r < 95) ? $urandom_range(4, 15) : $urandom_range(30, 120);
      r = $urandom_range(0, 99);
      burst = (r < 30) ? $urandom_range(1, 3) :
              (r < 40) ? $urandom_range(50, 200) : $urandom_range(4, 20);
      if (!held && random_part) begin
        held  = 1'b1;
        stall = LongHold;
      end
      m_axis_tready <= 1'b0;
      repeat (stall) @(posedge clk_i);
      m_axis_tready <= 1'b1;
      repeat (burst) @(posedge clk_i);
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    cycle_cnt     = 0;
    phase_items   = 0;
    tx_calm       = 0;
    random_part   = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // three terms, negative offsets, extremes of position and term
    cfg_terms = 3;
    cfg_stop  = 0;
    cfg_off   = '{-3, -4, -5, 1023, -1023, 7};
    load_config();
    send_item(CMD_POS, 3'd0, 20'd103);
    send_item(CMD_POS, 3'd0, 20'd1);
    send_item(CMD_POS, 3'd0, 20'hFFFFF);
    send_item(CMD_POS, 3'd1, 20'd104);
    send_item(CMD_POS, 3'd1, 20'd2);
    send_item(CMD_POS, 3'd1, 20'hFFFFF);
    send_item(CMD_POS, 3'd2, 20'd105);
    send_item(CMD_POS, 3'd2, 20'd3);
    send_item(CMD_POS, 3'd2, 20'd105);
    send_item(CMD_POS, 3'd3, 20'd0);
    send_item(CMD_POS, 3'd7, 20'hFFFFF);
    send_item(CmdUnused, 3'd5, 20'h55555);
    send_item(CMD_EOW, '0, '0);
    send_item(CMD_POS, 3'd1, 20'd104);
    send_item(CMD_EOD, '0, '0);
    wait_quiet();

    // term count above the maximum, stop after first match
    cfg_terms = 7;
    cfg_stop  = 1;
    cfg_off   = '{0, -1, -2, -3, -4, -5};
    load_config();
    for (int t = 0; t < MaxTermsDef; t++) send_item(CMD_POS, TermW'(t), PosW'(10 + t));
    send_item(CMD_POS, 3'd5, 20'd15);
    send_item(CMD_EOW, '0, '0);
    send_item(CMD_EOD, '0, '0);
    send_item(CMD_EOD, '0, '0);
    wait_quiet();

    random_part <= 1'b1;
    for (int ph = 0; ph < NumPhases; ph++) begin
      cfg_terms = ph;
      cfg_stop  = (ph % 3 == 2);
      for (int t = 0; t < MaxTermsDef; t++) begin
        case (ph)
          0:       cfg_off[t] = (t % 2 == 0) ? 1023 : -1023;
          1:       cfg_off[t] = -t;
          2:       cfg_off[t] = 0;
          default: cfg_off[t] = int'($urandom_range(0, 2046)) - 1023;
        endcase
      end
      load_config();
      phase_items = 0;
      while (phase_items < PhaseItems) send_doc();
      wait_quiet();
    end

    if (err_cnt == 0) begin
      $display("exact_phrase_position_matcher_tb: done, clean");
    end else begin
      $display("exact_phrase_position_matcher_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/pepm_pkg.sv
rtl/pepm_ram.sv
rtl/pepm_cfg.sv
rtl/pepm_front.sv
rtl/pepm_fifo.sv
rtl/pepm_back.sv
rtl/exact_phrase_position_matcher.sv
test/phrase_freq_checker.sv
test/exact_phrase_position_matcher_tb.sv
